>>> hw/rtl/cce_pkg.sv
// Shared types and constants of the Chebyshev curve evaluator.
// Depends on nothing; used by every cell and by the top level.
`default_nettype none
package cce_pkg;

    localparam int unsigned POS_W   = 16;   // sample position and range bounds
    localparam int unsigned COEF_W  = 32;   // Q16.16 coefficient
    localparam int unsigned DEG_W   = 3;
    localparam int unsigned NUM_REG = 8;
    localparam int unsigned NUM_COEF = 5;
    localparam int unsigned AD_W    = 16;   // |end - start|
    localparam int unsigned REM_W   = 34;   // |numerator| + |d|/2
    localparam int unsigned CMP_W   = 38;   // divisor shifted by up to QTOP
    localparam int unsigned QTOP    = 21;   // top quotient bit, flags overflow
    localparam int unsigned Q_W     = QTOP + 1;
    localparam int unsigned Z_W     = 20;   // Q4.16
    localparam int unsigned B_W     = 43;   // Q27.16 Clenshaw term
    localparam int unsigned SUM_W   = 50;
    localparam int unsigned PROD_W  = 64;
    localparam int unsigned OUT_W   = 32;

    localparam logic [2:0] REG_RANGE_START = 3'd0;
    localparam logic [2:0] REG_RANGE_END   = 3'd1;
    localparam logic [2:0] REG_DEGREE      = 3'd2;
    localparam logic [2:0] REG_COEF_T0     = 3'd3;

    // Item travelling through the divider cells.
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [Q_W-1:0]   q;
        logic [AD_W-1:0]  ad;
        logic             neg;
        logic             rerr;
    } t_div_item;

    // Item travelling through the Clenshaw cells.
    typedef struct packed {
        logic signed [Z_W-1:0] z;
        logic signed [B_W-1:0] b1;
        logic signed [B_W-1:0] b2;
        logic                  sat;
        logic                  rerr;
    } t_cl_item;

endpackage
`default_nettype wire

>>> hw/rtl/cce_div_cell.sv
// One restoring-division cell: decides quotient bit SHIFT.
// Depends on cce_pkg.
`default_nettype none
module cce_div_cell #(
    parameter int unsigned SHIFT = 0
) (
    input  wire                   i_clk,
    input  wire                   i_en,
    input  cce_pkg::t_div_item    i_item,
    output cce_pkg::t_div_item    o_item
);
    import cce_pkg::*;

    t_div_item        r_item;
    t_div_item        n_item;
    logic [CMP_W-1:0] dshift;
    logic [CMP_W-1:0] rem_ext;

    always_comb begin
        dshift  = {{(CMP_W-AD_W){1'b0}}, i_item.ad} << SHIFT;
        rem_ext = {{(CMP_W-REM_W){1'b0}}, i_item.rem};
        n_item  = i_item;
        if (rem_ext >= dshift) begin
            n_item.rem      = REM_W'(rem_ext - dshift);
            n_item.q[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule
`default_nettype wire

>>> hw/rtl/cce_clen_cell.sv
// One Clenshaw step b = c + round(2z*b1) - b2, clipped; product then sum stage.
// Depends on cce_pkg.
`default_nettype none
module cce_clen_cell (
    input  wire                          i_clk,
    input  wire                          i_en_a,
    input  wire                          i_en_b,
    input  wire  [cce_pkg::COEF_W-1:0]   i_coef,
    input  cce_pkg::t_cl_item            i_item,
    output cce_pkg::t_cl_item            o_item
);
    import cce_pkg::*;

    t_cl_item                 r_a;
    logic signed [PROD_W-1:0] r_p;
    t_cl_item                 r_b;
    t_cl_item                 n_b;
    logic signed [Z_W:0]      z2;
    logic signed [PROD_W-1:0] pr;
    logic signed [SUM_W-1:0]  sum;
    logic                     clip_hi;
    logic                     clip_lo;

    assign z2 = {i_item.z, 1'b0};

    always_ff @(posedge i_clk) begin
        if (i_en_a) begin
            r_a <= i_item;
            r_p <= PROD_W'(z2) * PROD_W'(i_item.b1);
        end
        if (i_en_b) begin
            r_b <= n_b;
        end
    end

    always_comb begin
        pr  = (r_p + PROD_W'(32768)) >>> 16;
        sum = SUM_W'($signed(i_coef)) + pr[SUM_W-1:0] - SUM_W'(r_a.b2);
        clip_hi = !sum[SUM_W-1] && (sum[SUM_W-2:B_W-1] != '0);
        clip_lo = sum[SUM_W-1] && (sum[SUM_W-2:B_W-1] != '1);
        n_b    = r_a;
        n_b.b2 = r_a.b1;
        if (clip_hi) begin
            n_b.b1 = {1'b0, {(B_W-1){1'b1}}};
        end else if (clip_lo) begin
            n_b.b1 = {1'b1, {(B_W-1){1'b0}}};
        end else begin
            n_b.b1 = sum[B_W-1:0];
        end
        n_b.sat = r_a.sat | clip_hi | clip_lo;
    end

    assign o_item = r_b;

endmodule
`default_nettype wire

>>> hw/rtl/chebyshev_curve_evaluator_unit.sv
// Chebyshev curve evaluator: one sample position in, one Q16.16 value out.
// Pipeline stages: front, 22 divider cells, z clip, two stages per
// Clenshaw cell, two output stages; throughput one item per cycle unless
// m_tready stalls the output, set by the fully pipelined divider and Clenshaw cell row.
// Synchronous active-low reset empties the pipeline and restores the
// registers to start 0, end 1023, degree 1, coefficients 0.
`default_nettype none
module chebyshev_curve_evaluator_unit #(
    parameter int unsigned MAX_DEGREE = 4
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // stream in
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,    // [15:0] sample_pos
    // stream out
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,    // [31:0] fitted_value
    output logic [1:0]  m_tuser,    // [0] saturated, [1] range_error
    // configuration
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [4:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cce_pkg::*;

    localparam int unsigned NCELL = MAX_DEGREE + 1;
    localparam int unsigned ST_DIV0 = 1;
    localparam int unsigned ST_Z   = ST_DIV0 + Q_W;
    localparam int unsigned ST_CL0 = ST_Z + 1;
    localparam int unsigned ST_FIN = ST_CL0 + 2 * NCELL;
    localparam int unsigned NS     = ST_FIN + 2;

    // ---------------- configuration registers ----------------
    logic signed [POS_W-1:0]  r_start;
    logic signed [POS_W-1:0]  r_end;
    logic [DEG_W-1:0]         r_deg;
    logic [COEF_W-1:0]        r_coef [NUM_COEF];
    logic                     wr;
    logic [2:0]               wsel;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite & pready;
    assign wsel   = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_end   <= POS_W'(1023);
            r_deg   <= DEG_W'(1);
            for (int i = 0; i < NUM_COEF; i++) begin
                r_coef[i] <= '0;
            end
        end else if (wr) begin
            case (wsel)
                REG_RANGE_START: r_start <= pwdata[POS_W-1:0];
                REG_RANGE_END:   r_end   <= pwdata[POS_W-1:0];
                REG_DEGREE:      r_deg   <= pwdata[DEG_W-1:0];
                default:         r_coef[3'(wsel - REG_COEF_T0)] <= pwdata;
            endcase
        end
    end

    always_comb begin
        case (wsel)
            REG_RANGE_START: prdata = 32'($signed(r_start));
            REG_RANGE_END:   prdata = 32'($signed(r_end));
            REG_DEGREE:      prdata = {{(32-DEG_W){1'b0}}, r_deg};
            default:         prdata = r_coef[3'(wsel - REG_COEF_T0)];
        endcase
    end

    // clamp the degree to 1..MAX_DEGREE
    logic [DEG_W-1:0] deg_eff;
    always_comb begin
        if (r_deg == '0) begin
            deg_eff = DEG_W'(1);
        end else if (r_deg > DEG_W'(MAX_DEGREE)) begin
            deg_eff = DEG_W'(MAX_DEGREE);
        end else begin
            deg_eff = r_deg;
        end
    end

    // ---------------- stage valids and advance chain ----------------
    // A stage loads when it is empty or the stage after it moves on.
    logic [NS-1:0] r_v;
    logic [NS-1:0] v_in;
    logic [NS:0]   adv;

    assign v_in = {r_v[NS-2:0], s_tvalid};

    always_comb begin
        adv[NS] = m_tready;
        for (int i = NS - 1; i >= 0; i--) begin
            adv[i] = !r_v[i] | adv[i+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int i = 0; i < NS; i++) begin
                if (adv[i]) begin
                    r_v[i] <= v_in[i];
                end
            end
        end
    end

    assign s_tready = adv[0];
    assign m_tvalid = r_v[NS-1];

    // ---------------- front: numerator and divisor ----------------
    logic signed [POS_W+2:0] t;
    logic signed [POS_W:0]   d;
    logic [POS_W+1:0]        at;
    logic [POS_W:0]          ad_full;
    t_div_item               n_front;
    t_div_item               r_front;
    t_div_item               div_s [Q_W+1];

    always_comb begin
        t  = (POS_W+3)'($signed({s_tdata, 1'b0})) - (POS_W+3)'(r_start) - (POS_W+3)'(r_end);
        d  = (POS_W+1)'(r_end) - (POS_W+1)'(r_start);
        at = t[POS_W+2] ? (POS_W+2)'(-t) : t[POS_W+1:0];
        ad_full = d[POS_W] ? (POS_W+1)'(-d) : d;
        n_front.ad   = ad_full[AD_W-1:0];
        n_front.rem  = REM_W'({at[POS_W:0], 16'b0}) + REM_W'(ad_full[AD_W-1:1]);
        n_front.q    = '0;
        n_front.neg  = t[POS_W+2] ^ d[POS_W];
        n_front.rerr = (d == '0);
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_front <= n_front;
        end
    end

    assign div_s[0] = r_front;

    // ---------------- divider cell row, top quotient bit first ----------------
    for (genvar j = 0; j < Q_W; j++) begin : g_div
        cce_div_cell #(.SHIFT(QTOP - j)) u_div (
            .i_clk  (i_clk),
            .i_en   (adv[ST_DIV0 + j]),
            .i_item (div_s[j]),
            .o_item (div_s[j+1])
        );
    end

    // ---------------- z clip ----------------
    // A quotient outside the Q4.16 range of z, as when the top quotient bit is set, is clipped.
    t_div_item dq;
    t_cl_item  n_z;
    t_cl_item  r_z;
    t_cl_item  cl_s [NCELL+1];

    assign dq = div_s[Q_W];

    always_comb begin
        n_z.b1   = '0;
        n_z.b2   = '0;
        n_z.rerr = dq.rerr;
        n_z.sat  = 1'b0;
        if (!dq.neg) begin
            if (dq.q > Q_W'(524287)) begin
                n_z.z   = {1'b0, {(Z_W-1){1'b1}}};
                n_z.sat = 1'b1;
            end else begin
                n_z.z = dq.q[Z_W-1:0];
            end
        end else begin
            if (dq.q > Q_W'(524288)) begin
                n_z.z   = {1'b1, {(Z_W-1){1'b0}}};
                n_z.sat = 1'b1;
            end else begin
                n_z.z = Z_W'(-dq.q);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[ST_Z]) begin
            r_z <= n_z;
        end
    end

    assign cl_s[0] = r_z;

    // ---------------- Clenshaw cell row, highest term first ----------------
    // Terms above the used degree take a zero coefficient and pass zeros on.
    for (genvar m = 0; m < NCELL; m++) begin : g_cl
        localparam int unsigned K = MAX_DEGREE - m;
        logic [COEF_W-1:0] coef_k;
        assign coef_k = (DEG_W'(K) <= deg_eff) ? r_coef[K] : '0;
        cce_clen_cell u_cl (
            .i_clk  (i_clk),
            .i_en_a (adv[ST_CL0 + 2*m]),
            .i_en_b (adv[ST_CL0 + 2*m + 1]),
            .i_coef (coef_k),
            .i_item (cl_s[m]),
            .o_item (cl_s[m+1])
        );
    end

    // ---------------- output: y = b0 - round(z*b1) ----------------
    t_cl_item                 r_fa;
    logic signed [PROD_W-1:0] r_fp;
    logic signed [PROD_W-1:0] fpr;
    logic signed [SUM_W-1:0]  ysum;
    logic [OUT_W-1:0]         r_y;
    logic                     r_sat;
    logic                     r_rerr;
    logic [OUT_W-1:0]         n_y;
    logic                     n_sat;
    logic                     yhi;
    logic                     ylo;

    always_comb begin
        fpr  = (r_fp + PROD_W'(32768)) >>> 16;
        ysum = SUM_W'(r_fa.b1) - fpr[SUM_W-1:0];
        yhi  = !ysum[SUM_W-1] && (ysum[SUM_W-2:OUT_W-1] != '0);
        ylo  = ysum[SUM_W-1] && (ysum[SUM_W-2:OUT_W-1] != '1);
        if (r_fa.rerr) begin
            n_y   = '0;
            n_sat = 1'b0;
        end else begin
            if (yhi) begin
                n_y = {1'b0, {(OUT_W-1){1'b1}}};
            end else if (ylo) begin
                n_y = {1'b1, {(OUT_W-1){1'b0}}};
            end else begin
                n_y = ysum[OUT_W-1:0];
            end
            n_sat = r_fa.sat | yhi | ylo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[ST_FIN]) begin
            r_fa <= cl_s[NCELL];
            r_fp <= PROD_W'(cl_s[NCELL].z) * PROD_W'(cl_s[NCELL].b2);
        end
        if (adv[ST_FIN+1]) begin
            r_y    <= n_y;
            r_sat  <= n_sat;
            r_rerr <= r_fa.rerr;
        end
    end

    assign m_tdata = r_y;
    assign m_tuser = {r_rerr, r_sat};

endmodule
`default_nettype wire

>>> hw/rtl/cce_checker.sv
// Port-level checks for the Chebyshev curve evaluator, bound to the top level.
// Depends on chebyshev_curve_evaluator_unit.
`default_nettype none
module cce_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [31:0] m_tdata,
    input wire [1:0]  m_tuser,
    input wire        pready
);

    // a stalled result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // an empty range gives zero and no saturation
    a_rerr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser[1] |-> m_tdata == 32'd0 && !m_tuser[0])
        else $error("range error with nonzero result");

    // reset empties the pipeline
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");

    // configuration port never waits
    a_rdy: assert property (@(posedge i_clk) pready)
        else $error("pready low");

endmodule

bind chebyshev_curve_evaluator_unit cce_checker u_cce_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .pready   (pready)
);
`default_nettype wire

>>> sim/testbench.sv
// Self-checking bench for the Chebyshev curve evaluator unit.
// Predicts each Q16.16 curve value from the register settings and compares it
// with the output stream. Depends on cce_pkg and chebyshev_curve_evaluator_unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import cce_pkg::*;

    localparam int LATENCY = 2 * 4 + 28;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    chebyshev_curve_evaluator_unit dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the register file
    logic signed [15:0] span_lo, span_hi;
    logic [2:0]         degree_reg;
    logic signed [31:0] coefs [5];

    typedef struct packed {
        logic [31:0] value;
        logic        sat;
        logic        rerr;
    } curve_point_t;

    curve_point_t pending_points[$];
    int  failures = 0;
    int  idle_cycles = 0;
    bit  stalls_on = 1'b1;

    function automatic longint floor_q16(longint p);
        if (p >= 0) return p / 65536;
        return -((-p + 65535) / 65536);
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi, ref bit sat);
        if (v < lo) begin sat = 1; return lo; end
        if (v > hi) begin sat = 1; return hi; end
        return v;
    endfunction

    // Normalise the position, then run the Clenshaw recurrence downwards
    function automatic curve_point_t evaluate_curve(logic signed [15:0] xpos);
        curve_point_t r;
        longint d, num, an, ad, q, z, b1, b2, b, y;
        bit sat;
        int deg;
        sat = 0;
        d = longint'(span_hi) - longint'(span_lo);
        r = '0;
        if (d == 0) begin
            r.rerr = 1'b1;
            return r;
        end
        num = (2 * longint'(xpos) - span_lo - span_hi) * 65536;
        an = num < 0 ? -num : num;
        ad = d < 0 ? -d : d;
        q = (an + ad / 2) / ad;
        if ((num < 0) != (d < 0)) q = -q;
        z = clamp(q, -524288, 524287, sat);
        deg = degree_reg;
        if (deg < 1) deg = 1;
        if (deg > 4) deg = 4;
        b1 = 0; b2 = 0;
        for (int k = deg; k >= 0; k--) begin
            b = longint'(coefs[k]) + floor_q16(2 * z * b1 + 32768) - b2;
            b = clamp(b, -(64'sd1 <<< 42), (64'sd1 <<< 42) - 1, sat);
            b2 = b1;
            b1 = b;
        end
        y = b1 - floor_q16(z * b2 + 32768);
        y = clamp(y, -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1, sat);
        r.value = y[31:0];
        r.sat = sat;
        return r;
    endfunction

    // Receiver: stall on its own pattern, check each accepted item
    always @(posedge i_clk) begin
        curve_point_t exp_pt;
        if (i_rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (m_tvalid && m_tready) begin
                if (pending_points.size() == 0) begin
                    $error("result with nothing expected: %h", m_tdata);
                    failures++;
                end else begin
                    exp_pt = pending_points.pop_front();
                    if (m_tdata !== exp_pt.value) begin
                        $error("fitted_value expected %h actual %h", exp_pt.value, m_tdata);
                        failures++;
                    end
                    if (m_tuser[0] !== exp_pt.sat) begin
                        $error("saturated expected %b actual %b", exp_pt.sat, m_tuser[0]);
                        failures++;
                    end
                    if (m_tuser[1] !== exp_pt.rerr) begin
                        $error("range_error expected %b actual %b", exp_pt.rerr, m_tuser[1]);
                        failures++;
                    end
                end
            end
            m_tready <= stalls_on ? ($urandom_range(0, 3) != 0) : 1'b1;
            if ($urandom_range(0, 199) == 0) stalls_on <= ~stalls_on;
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Write one register over the configuration port: setup then access
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_RANGE_START: span_lo = val[15:0];
            REG_RANGE_END:   span_hi = val[15:0];
            REG_DEGREE:      degree_reg = val[2:0];
            default:         coefs[idx - REG_COEF_T0] = val;
        endcase
    endtask

    // Hold valid until the item is taken; the prediction is queued on acceptance
    task automatic send_position(logic [15:0] xpos);
        s_tvalid <= 1'b1;
        s_tdata <= xpos;
        do @(posedge i_clk); while (!s_tready);
        pending_points = {pending_points, evaluate_curve(xpos)};
    endtask

    task automatic drop_valid_for_gap();
        int gap;
        gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Wait for the pipeline to drain before touching registers
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic send_burst(int n, bit in_span);
        int burst;
        int lo, hi;
        lo = span_lo < span_hi ? span_lo : span_hi;
        hi = span_lo < span_hi ? span_hi : span_lo;
        burst = 0;
        for (int i = 0; i < n; i++) begin
            if (burst == 0) begin
                drop_valid_for_gap();
                burst = $urandom_range(1, 20);
            end
            if (in_span && $urandom_range(0, 3) != 0)
                send_position(16'(lo + int'($urandom_range(0, hi - lo))));
            else
                send_position(16'($urandom));
            burst--;
        end
    endtask

    task automatic test_reset_defaults();
        span_lo = 0; span_hi = 1023; degree_reg = 1;
        foreach (coefs[i]) coefs[i] = 0;
        send_position(16'h0000);
        send_position(16'h03FF);
        drain();
    endtask

    task automatic test_directed_extremes();
        write_reg(REG_RANGE_START, 32'h0000_0000);
        write_reg(REG_RANGE_END, 32'h0000_0400);
        write_reg(REG_DEGREE, 32'd4);
        for (int k = 0; k < 5; k++)
            write_reg(3'(REG_COEF_T0 + k), 32'(32'h0001_0000 * (k + 1)));
        send_position(16'h0000);
        send_position(16'h0400);
        send_position(16'h0200);
        send_position(16'h7FFF);   // z clips high
        send_position(16'h8000);   // z clips low
        drain();
        // huge coefficients drive the internal terms and y into clipping
        for (int k = 0; k < 5; k++)
            write_reg(3'(REG_COEF_T0 + k), k[0] ? 32'h8000_0000 : 32'h7FFF_FFFF);
        send_position(16'h7FFF);
        send_position(16'h8000);
        send_position(16'h0100);
        drain();
        // empty range
        write_reg(REG_RANGE_END, 32'h0000_0000);
        send_position(16'h0000);
        send_position(16'h1234);
        drain();
        // reversed, full-width range and degree codes 0 and 7
        write_reg(REG_RANGE_START, 32'h0000_7FFF);
        write_reg(REG_RANGE_END, 32'h0000_8000);
        write_reg(REG_DEGREE, 32'd0);
        send_position(16'h7FFF);
        send_position(16'h8000);
        drain();
        write_reg(REG_DEGREE, 32'd7);
        send_position(16'hFFFF);
        send_position(16'h0001);
        drain();
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 12; phase++) begin
            write_reg(REG_RANGE_START, $urandom);
            write_reg(REG_RANGE_END, (phase % 6 == 5) ? {16'h0, span_lo} :
                      ($urandom_range(0, 1) ? 32'(span_lo + $urandom_range(1, 4000)) : $urandom));
            write_reg(REG_DEGREE, $urandom_range(0, 7));
            for (int k = 0; k < 5; k++)
                write_reg(3'(REG_COEF_T0 + k), phase[0] ? $urandom :
                          $signed($urandom_range(0, 32'h3FFFF)) - 32'h1FFFF);
            send_burst(50, 1'b1);
            drain();
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_directed_extremes();
        test_random_settings();
        if (failures == 0 && pending_points.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
